### rtl/dpr_pkg.sv
// Shared types and constants of the duotone pixel recolor unit.
`default_nettype none

package dpr_pkg;

	// Channel and register widths
	localparam int PIX_W     = 8;
	localparam int OPA_W     = 7;
	localparam int CFG_W     = 8;
	localparam int REG_IDX_W = 3;
	localparam int NUM_CH    = 3;

	// Blend math: colour channels divide by 255, alpha by 100 * 255
	localparam int               BLEND_ROUND = 127;
	localparam logic [OPA_W-1:0] OPA_MAX     = OPA_W'(100);
	localparam int               ALPHA_DIV   = 25500;
	localparam int               ALPHA_HALF  = ALPHA_DIV / 2;
	localparam int               RECIP_SH    = 32;
	localparam int               RECIP_W     = 18;
	localparam logic [RECIP_W-1:0] ALPHA_RECIP =
		RECIP_W'((64'd1 << RECIP_SH) / ALPHA_DIV);

	// Register map
	typedef enum logic [REG_IDX_W-1:0] {
		REG_WIRE_RED     = 3'd0,
		REG_WIRE_GREEN   = 3'd1,
		REG_WIRE_BLUE    = 3'd2,
		REG_FACE_RED     = 3'd3,
		REG_FACE_GREEN   = 3'd4,
		REG_FACE_BLUE    = 3'd5,
		REG_FACE_OPACITY = 3'd6,
		REG_WIRE_OPACITY = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [PIX_W-1:0] in_alpha;
		logic [PIX_W-1:0] in_red;
		logic [PIX_W-1:0] in_green;
		logic [PIX_W-1:0] in_blue;
	} pix_in_t;

	typedef struct packed {
		logic [PIX_W-1:0] out_alpha;
		logic [PIX_W-1:0] out_red;
		logic [PIX_W-1:0] out_green;
		logic [PIX_W-1:0] out_blue;
	} pix_out_t;

	// Lane 0 red, lane 1 green, lane 2 blue
	typedef struct packed {
		logic [NUM_CH-1:0][PIX_W-1:0] wire_col;
		logic [NUM_CH-1:0][PIX_W-1:0] face_col;
	} col_cfg_t;

	typedef struct packed {
		logic [OPA_W-1:0] face_opa;
		logic [OPA_W-1:0] wire_opa;
	} opa_cfg_t;

endpackage

`default_nettype wire

### rtl/dpr_chan.sv
// Colour blend lanes: wire colour toward face colour by t/255, stages 2 to 4.
`default_nettype none

module dpr_chan
	import dpr_pkg::*;
(
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         vld_s1,
	input  wire logic [PIX_W-1:0]             t_s1,
	input  wire logic [PIX_W-1:0]             inv_s1,
	input  wire col_cfg_t                     col_cfg,
	output logic                              vld_s4,
	output logic [NUM_CH-1:0][PIX_W-1:0]      col_s4
);

	logic                               vld_s2, vld_s3;
	logic [NUM_CH-1:0][2*PIX_W-1:0]     prod_w_s2, prod_f_s2;
	logic [NUM_CH-1:0][2*PIX_W-1:0]     sum_s3;
	logic [NUM_CH-1:0][2*PIX_W:0]       div_tmp;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// Divide by 255 exactly for sums below 65535
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			div_tmp[c] = (2*PIX_W+1)'(sum_s3[c]) + (2*PIX_W+1)'(1)
				+ (2*PIX_W+1)'(sum_s3[c][2*PIX_W-1:PIX_W]);
		end
	end

	// Products, rounded sum, quotient
	always_ff @(posedge clk) begin
		for (int c = 0; c < NUM_CH; c++) begin
			prod_w_s2[c] <= (2*PIX_W)'(col_cfg.wire_col[c]) * (2*PIX_W)'(inv_s1);
			prod_f_s2[c] <= (2*PIX_W)'(col_cfg.face_col[c]) * (2*PIX_W)'(t_s1);
			sum_s3[c]    <= prod_w_s2[c] + prod_f_s2[c] + (2*PIX_W)'(BLEND_ROUND);
			col_s4[c]    <= div_tmp[c][2*PIX_W-1:PIX_W];
		end
	end

endmodule

`default_nettype wire

### rtl/dpr_alpha.sv
// Alpha path: opacity blend, alpha scale and rounded divide by 25500, stages 2 to 7.
`default_nettype none

module dpr_alpha
	import dpr_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               vld_s1,
	input  wire logic [PIX_W-1:0]   alpha_s1,
	input  wire logic [PIX_W-1:0]   t_s1,
	input  wire logic [PIX_W-1:0]   inv_s1,
	input  wire opa_cfg_t           opa_cfg,
	output logic                    vld_s7,
	output logic [PIX_W-1:0]        alpha_s7
);

	localparam int WGT_W  = OPA_W + PIX_W;
	localparam int PROD_W = WGT_W + PIX_W;
	localparam int SCL_W  = PROD_W + RECIP_W;
	localparam int QUO_W  = SCL_W - RECIP_SH;
	localparam int REM_W  = 16;

	logic                   vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic [PIX_W-1:0]       a_s2, a_s3;
	logic [WGT_W-1:0]       pw_s2, pf_s2, weight_s3;
	logic [PROD_W-1:0]      prod_s4, x_s5;
	logic [SCL_W-1:0]       scaled;
	logic [QUO_W-1:0]       q0_s5, q0_s6;
	logic [PROD_W-1:0]      rem_full;
	logic [REM_W-1:0]       rem_s6;
	logic [QUO_W:0]         q_fix;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// Reciprocal estimate is the true quotient or one below it
	assign scaled   = SCL_W'(prod_s4) * SCL_W'(ALPHA_RECIP);
	assign rem_full = x_s5 - PROD_W'(q0_s5) * PROD_W'(ALPHA_DIV);
	assign q_fix    = (QUO_W+1)'(q0_s6)
		+ (QUO_W+1)'(rem_s6 >= REM_W'(ALPHA_DIV));

	// Weight, scale, divide, correct
	always_ff @(posedge clk) begin
		pw_s2     <= WGT_W'(opa_cfg.wire_opa) * WGT_W'(inv_s1);
		pf_s2     <= WGT_W'(opa_cfg.face_opa) * WGT_W'(t_s1);
		a_s2      <= alpha_s1;
		weight_s3 <= pw_s2 + pf_s2;
		a_s3      <= a_s2;
		prod_s4   <= PROD_W'(a_s3) * PROD_W'(weight_s3) + PROD_W'(ALPHA_HALF);
		x_s5      <= prod_s4;
		q0_s5     <= scaled[SCL_W-1:RECIP_SH];
		q0_s6     <= q0_s5;
		rem_s6    <= rem_full[REM_W-1:0];
		alpha_s7  <= (q_fix > (QUO_W+1)'({PIX_W{1'b1}})) ? {PIX_W{1'b1}}
			: q_fix[PIX_W-1:0];
	end

	// Remainder stays below twice the divisor after the estimate
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s6 |-> (rem_s6 < REM_W'(2 * ALPHA_DIV)))
		else $error("alpha remainder out of correction range");

	// Estimate never overshoots the dividend
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 |-> (PROD_W'(q0_s5) * PROD_W'(ALPHA_DIV) <= x_s5))
		else $error("alpha quotient estimate too large");

endmodule

`default_nettype wire

### rtl/duotone_pixel_recolor_unit.sv
// Top level of the duotone pixel recolor unit: registers, max stage, output alignment.
//
//  channel   signals                          transfer when
//  -------   -------------------------------  -----------------------------
//  pixel in  start, busy, pix_in              start high and busy low
//  pixel out done, pix_out                    done high (one cycle, no hold)
//  config    cfg_we, cfg_idx, cfg_wdata       cfg_we high
//
// One pixel per clock; each result is registered through stage 1 and then the alpha
// path (opacity blend, alpha multiply, reciprocal divide, correction), the longer path.
// busy is always low: nothing downstream can stall the pipeline.
// Reset clears the valid bits and loads the register reset colours.
// The user must write registers only while no pixel is in flight; the block does not enforce it.
`default_nettype none

module duotone_pixel_recolor_unit
	import dpr_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire pix_in_t               pix_in,
	output logic                       done,
	output pix_out_t                   pix_out,
	input  wire logic                  cfg_we,
	input  wire logic [REG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_W-1:0]      cfg_wdata
);

	col_cfg_t                          col_cfg_q;
	opa_cfg_t                          opa_cfg_q;
	logic [OPA_W-1:0]                  opa_sat;
	logic                              vld_s1;
	logic [PIX_W-1:0]                  alpha_s1, t_s1, inv_s1;
	logic [PIX_W-1:0]                  max_rg, max_rgb;
	logic                              cvld_s4, cvld_s5, cvld_s6, cvld_s7;
	logic [NUM_CH-1:0][PIX_W-1:0]      col_s4, col_s5, col_s6, col_s7;
	logic                              avld_s7;
	logic [PIX_W-1:0]                  alpha_s7;

	assign busy = 1'b0;

	// Saturate opacity at one hundred percent on write
	assign opa_sat = (cfg_wdata[OPA_W-1:0] > OPA_MAX) ? OPA_MAX : cfg_wdata[OPA_W-1:0];

	// Register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_cfg_q.wire_col <= '0;
			col_cfg_q.face_col <= '1;
			opa_cfg_q.face_opa <= OPA_MAX;
			opa_cfg_q.wire_opa <= OPA_MAX;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_WIRE_RED:     col_cfg_q.wire_col[0] <= cfg_wdata;
				REG_WIRE_GREEN:   col_cfg_q.wire_col[1] <= cfg_wdata;
				REG_WIRE_BLUE:    col_cfg_q.wire_col[2] <= cfg_wdata;
				REG_FACE_RED:     col_cfg_q.face_col[0] <= cfg_wdata;
				REG_FACE_GREEN:   col_cfg_q.face_col[1] <= cfg_wdata;
				REG_FACE_BLUE:    col_cfg_q.face_col[2] <= cfg_wdata;
				REG_FACE_OPACITY: opa_cfg_q.face_opa    <= opa_sat;
				REG_WIRE_OPACITY: opa_cfg_q.wire_opa    <= opa_sat;
				default: begin
				end
			endcase
		end
	end

	// Brightness is the largest colour channel
	assign max_rg  = (pix_in.in_green > pix_in.in_red) ? pix_in.in_green : pix_in.in_red;
	assign max_rgb = (pix_in.in_blue > max_rg) ? pix_in.in_blue : max_rg;

	// Stage 1 valid and output alignment valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			cvld_s5 <= 1'b0;
			cvld_s6 <= 1'b0;
			cvld_s7 <= 1'b0;
		end else begin
			vld_s1  <= start && !busy;
			cvld_s5 <= cvld_s4;
			cvld_s6 <= cvld_s5;
			cvld_s7 <= cvld_s6;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		alpha_s1 <= pix_in.in_alpha;
		t_s1     <= max_rgb;
		inv_s1   <= {PIX_W{1'b1}} - max_rgb;
	end

	// Hold blended colours until alpha catches up
	always_ff @(posedge clk) begin
		if (cvld_s4) begin
			col_s5 <= col_s4;
		end
		if (cvld_s5) begin
			col_s6 <= col_s5;
		end
		if (cvld_s6) begin
			col_s7 <= col_s6;
		end
	end

	dpr_chan u_chan (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_s1  (vld_s1),
		.t_s1    (t_s1),
		.inv_s1  (inv_s1),
		.col_cfg (col_cfg_q),
		.vld_s4  (cvld_s4),
		.col_s4  (col_s4)
	);

	dpr_alpha u_alpha (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_s1   (vld_s1),
		.alpha_s1 (alpha_s1),
		.t_s1     (t_s1),
		.inv_s1   (inv_s1),
		.opa_cfg  (opa_cfg_q),
		.vld_s7   (avld_s7),
		.alpha_s7 (alpha_s7)
	);

	// Drive the result
	assign done              = avld_s7;
	assign pix_out.out_alpha = alpha_s7;
	assign pix_out.out_red   = col_s7[0];
	assign pix_out.out_green = col_s7[1];
	assign pix_out.out_blue  = col_s7[2];

	// Colour and alpha paths stay in step
	assert property (@(posedge clk) disable iff (!arst_n) cvld_s7 == avld_s7)
		else $error("colour and alpha valids out of step");

	// Every accepted pixel yields a result on done after stage 1 and the alpha stages
	assert property (@(posedge clk) disable iff (!arst_n) start |-> ##7 done)
		else $error("accepted pixel produced no result");

endmodule

`default_nettype wire

### bench/tb.sv
// Self-checking testbench for the duotone pixel recolor unit.
`timescale 1ns / 1ps

module tb;
	import dpr_pkg::*;

	localparam int unsigned FULL_SCALE = 255;
	localparam int unsigned ALPHA_DEN  = 51000;
	localparam int unsigned ALPHA_BIAS = 25500;
	localparam int          CYCLE_LIMIT = 200000;
	localparam int          DRAIN_CYCLES = 12;
	localparam int          RANDOM_PHASES = 8;
	localparam int          PHASE_PIXELS = 212;

	// Predicts recolored pixels and checks them in order against the block
	class recolor_scoreboard;
		logic [PIX_W-1:0] wire_col [3];
		logic [PIX_W-1:0] face_col [3];
		logic [OPA_W-1:0] face_opa;
		logic [OPA_W-1:0] wire_opa;
		pix_out_t         expected_pixels [$];
		int               mismatch_count;

		function new();
			for (int i = 0; i < 3; i++) begin
				wire_col[i] = '0;
				face_col[i] = '1;
			end
			face_opa = OPA_MAX;
			wire_opa = OPA_MAX;
			mismatch_count = 0;
		endfunction

		// Track a register write; bits above the register width are dropped
		function void write_reg(reg_idx_t idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_WIRE_RED:     wire_col[0] = data;
				REG_WIRE_GREEN:   wire_col[1] = data;
				REG_WIRE_BLUE:    wire_col[2] = data;
				REG_FACE_RED:     face_col[0] = data;
				REG_FACE_GREEN:   face_col[1] = data;
				REG_FACE_BLUE:    face_col[2] = data;
				REG_FACE_OPACITY: face_opa = data[OPA_W-1:0];
				REG_WIRE_OPACITY: wire_opa = data[OPA_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [PIX_W-1:0] blend(logic [PIX_W-1:0] w, logic [PIX_W-1:0] f,
				int unsigned t);
			int unsigned num;
			num = w * (FULL_SCALE - t) + f * t + BLEND_ROUND;
			return PIX_W'(num / FULL_SCALE);
		endfunction

		function pix_out_t recolor(pix_in_t px);
			int unsigned t, fo, wo, weight, alpha;
			pix_out_t    res;
			t = px.in_red;
			if (px.in_green > t)
				t = px.in_green;
			if (px.in_blue > t)
				t = px.in_blue;
			// Opacity percentages saturate at one hundred
			fo = (face_opa > OPA_MAX) ? OPA_MAX : face_opa;
			wo = (wire_opa > OPA_MAX) ? OPA_MAX : wire_opa;
			weight = wo * (FULL_SCALE - t) + fo * t;
			alpha = (2 * px.in_alpha * weight + ALPHA_BIAS) / ALPHA_DEN;
			res.out_alpha = (alpha > FULL_SCALE) ? '1 : PIX_W'(alpha);
			res.out_red   = blend(wire_col[0], face_col[0], t);
			res.out_green = blend(wire_col[1], face_col[1], t);
			res.out_blue  = blend(wire_col[2], face_col[2], t);
			return res;
		endfunction

		// Note an accepted input transfer
		function void log_pixel(pix_in_t px);
			expected_pixels.push_back(recolor(px));
		endfunction

		function void check_field(string name, logic [PIX_W-1:0] exp_v,
				logic [PIX_W-1:0] act_v);
			if (act_v !== exp_v) begin
				$error("%s: expected %0d, got %0d", name, exp_v, act_v);
				mismatch_count++;
			end
		endfunction

		// Compare one result transfer with the oldest prediction
		function void check_pixel(pix_out_t got);
			pix_out_t want;
			if (expected_pixels.size() == 0) begin
				$error("result with no pixel outstanding: %h", got);
				mismatch_count++;
				return;
			end
			want = expected_pixels.pop_front();
			check_field("out_alpha", want.out_alpha, got.out_alpha);
			check_field("out_red",   want.out_red,   got.out_red);
			check_field("out_green", want.out_green, got.out_green);
			check_field("out_blue",  want.out_blue,  got.out_blue);
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	pix_in_t              pix_in = '0;
	logic                 done;
	pix_out_t             pix_out;
	logic                 cfg_we = 1'b0;
	logic [REG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_W-1:0]     cfg_wdata = '0;

	recolor_scoreboard sb;
	pix_in_t           pixel_backlog [$];
	int                gap_max = 0;
	int                cycle_count = 0;

	duotone_pixel_recolor_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.pix_in    (pix_in),
		.done      (done),
		.pix_out   (pix_out),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always #2 clk = ~clk;

	// Bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Check every result transfer
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_pixel(pix_out);
	end

	function automatic void queue_pixel(logic [31:0] argb);
		pixel_backlog.push_back(pix_in_t'(argb));
	endfunction

	function automatic pix_in_t rand_pixel();
		pix_in_t p;
		p = pix_in_t'($urandom);
		case ($urandom_range(0, 9))
			0: p.in_alpha = '1;
			1: p.in_alpha = '0;
			2: p.in_red = '1;
			3: p.in_blue = '1;
			4: begin
				p.in_green = p.in_red;
				p.in_blue  = p.in_red;
			end
			5: begin
				p.in_red   = PIX_W'($urandom_range(0, 3));
				p.in_green = PIX_W'($urandom_range(0, 3));
				p.in_blue  = PIX_W'($urandom_range(0, 3));
			end
			default: ;
		endcase
		return p;
	endfunction

	function automatic logic [CFG_W-1:0] rand_opacity();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return CFG_W'(OPA_MAX);
			2: return CFG_W'($urandom_range(101, 127));
			3: return CFG_W'($urandom_range(128, 255));
			default: return CFG_W'($urandom_range(0, 100));
		endcase
	endfunction

	task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		sb.write_reg(idx, data);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Write all registers; entry i goes to register index i
	task automatic apply_setting(logic [7:0][CFG_W-1:0] setting);
		for (int i = 0; i < 8; i++)
			write_reg(reg_idx_t'(i), setting[i]);
	endtask

	// Send the backlog in bursts with random gaps; one drive per edge
	task automatic drive_pixels();
		int  burst_left;
		int  gap_left;
		bit  offered;
		burst_left = $urandom_range(1, 30);
		gap_left = 0;
		offered = 1'b0;
		while (pixel_backlog.size() != 0 || offered) begin
			@(posedge clk);
			if (offered && !busy) begin
				sb.log_pixel(pix_in);
				offered = 1'b0;
			end
			if (!offered) begin
				if (gap_left > 0 || pixel_backlog.size() == 0) begin
					start <= 1'b0;
					if (gap_left > 0)
						gap_left--;
				end else begin
					start  <= 1'b1;
					pix_in <= pixel_backlog.pop_front();
					offered = 1'b1;
					burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 30);
						gap_left = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
					end
				end
			end
		end
	endtask

	task automatic wait_drained();
		while (sb.expected_pixels.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_backlog();
		drive_pixels();
		wait_drained();
	endtask

	initial begin : stimulus
		logic [7:0][CFG_W-1:0] setting;
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Reset colors: black wire, white face, full opacity
		gap_max = 0;
		queue_pixel(32'h00000000);
		queue_pixel(32'hFFFFFFFF);
		queue_pixel(32'hFF000000);
		queue_pixel(32'hFFFF0000);
		queue_pixel(32'h8000FF00);
		queue_pixel(32'h010000FF);
		queue_pixel(32'hFF807F01);
		queue_pixel(32'h7F55AA33);
		run_backlog();

		// Odd colors, opacity written with a dropped top bit and above one hundred
		setting = {8'h7F, 8'hE5, 8'hEF, 8'hCD, 8'hAB, 8'h56, 8'h34, 8'h12};
		apply_setting(setting);
		gap_max = 3;
		queue_pixel(32'hFF000000);
		queue_pixel(32'hFFFFFFFF);
		queue_pixel(32'hC8409020);
		queue_pixel(32'hFF010203);
		run_backlog();

		// Inverted ramp with both opacities at zero
		setting = {8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF};
		apply_setting(setting);
		queue_pixel(32'hFF000000);
		queue_pixel(32'hFFFFFFFF);
		queue_pixel(32'hFF808080);
		run_backlog();

		// Opacity ramp from zero to full, rounding near the midpoint
		setting = {8'h00, 8'h64, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00};
		apply_setting(setting);
		queue_pixel(32'hFFFFFFFF);
		queue_pixel(32'hFF000000);
		queue_pixel(32'hFF7F0000);
		queue_pixel(32'hFF800000);
		queue_pixel(32'h01008000);
		run_backlog();

		// Random phases: all-low and all-high settings first, then random ones
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			if (ph == 0) begin
				setting = '0;
			end else if (ph == 1) begin
				setting = '1;
			end else begin
				for (int i = 0; i < 6; i++)
					setting[i] = CFG_W'($urandom);
				setting[REG_FACE_OPACITY] = rand_opacity();
				setting[REG_WIRE_OPACITY] = rand_opacity();
			end
			apply_setting(setting);
			gap_max = (ph % 3 == 0) ? 0 : ph + 1;
			for (int n = 0; n < PHASE_PIXELS; n++)
				pixel_backlog.push_back(rand_pixel());
			run_backlog();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatch_count == 0 && sb.expected_pixels.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
